// ----- rtl/crse_pkg.sv -----
// ----------------------------------------------------------------------------
// crse_pkg
// Shared types and constants of the Catmull-Rom spline evaluation unit.
// ----------------------------------------------------------------------------
package crse_pkg;

  localparam int COORD_W = 32;           // signed Q16.16 coordinate
  localparam int T_FRAC  = 16;           // fraction bits of the spline parameter
  localparam int T_W     = T_FRAC + 1;   // parameter width, holds 1.0
  localparam int INDEX_W = 6;
  localparam int TOTAL_W = 7;
  localparam int W_W     = T_FRAC + 4;   // doubled basis weight, signed
  localparam int STEP_W  = 3;

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

  // MAC schedule: issue reads, multiply, accumulate, one step each
  localparam logic [STEP_W-1:0] STEP_LAST_ISSUE = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_FIRST_MUL  = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_LAST_MUL   = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_FIRST_ACC  = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_LAST       = STEP_W'(5);

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_EVAL   = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef struct packed {
    action_t                    action;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;
    logic [T_W-1:0]             param_t;
    logic [INDEX_W-1:0]         point_index;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic signed [COORD_W-1:0]  out_z;
    logic [TOTAL_W-1:0]         point_total;
    status_t                    status;
    logic                       saturated;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic              load_item;
    logic              read_point;
    logic              calc_u;
    logic              calc_sq;
    logic              calc_cube;
    logic              calc_wgt;
    logic              mac_run;
    logic [STEP_W-1:0] mac_step;
    logic              commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
  } dp_status_t;

endpackage

// ----- rtl/crse_ram.sv -----
// ----------------------------------------------------------------------------
// crse_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module crse_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/crse_ctrl.sv -----
// ----------------------------------------------------------------------------
// crse_ctrl
// Sequencer of the spline unit: accepts transactions, steps the datapath
// through each action and owns the result valid flag.
// ----------------------------------------------------------------------------
module crse_ctrl import crse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  action_t    in_action,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_READ = 8'b0000_0010,
    S_U    = 8'b0000_0100,
    S_SQ   = 8'b0000_1000,
    S_CUBE = 8'b0001_0000,
    S_WGT  = 8'b0010_0000,
    S_MAC  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;
  logic              accept;
  logic              commit;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // result slot is free once the previous transaction leaves this cycle
  assign commit   = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_APPEND, ACT_CLEAR: state_next = S_DONE;
            ACT_READ:              state_next = S_READ;
            ACT_EVAL:              state_next = status.count_zero ? S_DONE : S_U;
          endcase
        end
      end
      S_READ: state_next = S_DONE;
      S_U:    state_next = S_SQ;
      S_SQ:   state_next = S_CUBE;
      S_CUBE: state_next = S_WGT;
      S_WGT: begin
        step_next  = '0;
        state_next = S_MAC;
      end
      S_MAC: begin
        step_next = step + STEP_W'(1);
        if (step == STEP_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.load_item  = accept;
    cmd.read_point = (state == S_READ);
    cmd.calc_u     = (state == S_U);
    cmd.calc_sq    = (state == S_SQ);
    cmd.calc_cube  = (state == S_CUBE);
    cmd.calc_wgt   = (state == S_WGT);
    cmd.mac_run    = (state == S_MAC);
    cmd.mac_step   = step;
    cmd.commit     = commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/crse_dpath.sv -----
// ----------------------------------------------------------------------------
// crse_dpath
// Datapath of the spline unit: point memory, point count, segment and
// basis weight registers, three multiply-accumulate lanes and result register.
// ----------------------------------------------------------------------------
module crse_dpath import crse_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output out_item_t  out_data
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int U_W    = T_W + CNT_W;
  localparam int NI_W   = CNT_W + 2;
  localparam int PROD_W = COORD_W + W_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int SH_W   = ACC_W - (T_FRAC + 1);
  localparam int MEM_W  = 3 * COORD_W;

  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  in_item_t                  item;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          seg;
  logic [T_FRAC-1:0]         lt;
  logic [T_FRAC-1:0]         t2;
  logic [T_FRAC-1:0]         t3;
  logic signed [W_W-1:0]     wgt [4];
  logic signed [PROD_W-1:0]  prod [3];
  logic signed [ACC_W-1:0]   acc [3];

  logic [T_W-1:0]            t_clamp;
  logic [U_W-1:0]            u_full;
  logic [2*T_FRAC-1:0]       sq_full;
  logic [2*T_FRAC-1:0]       cube_full;
  logic signed [W_W-1:0]     s2, s3, sl, two;
  logic signed [NI_W-1:0]    nb, last;
  logic [AW-1:0]             nb_addr;
  logic                      issue, mult, accum;
  logic signed [W_W-1:0]     w_sel;
  logic signed [COORD_W-1:0] pt [3];
  logic                      full;
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [MEM_W-1:0]          ram_rdata;
  logic [COORD_W:0]          fin [3];
  out_item_t                 out_next;

  // floor(acc / 2^(F+1)) and saturate; MSB of the result flags saturation
  function automatic logic [COORD_W:0] finish(input logic signed [ACC_W-1:0] a);
    logic signed [SH_W-1:0]    sh;
    logic [SH_W-COORD_W:0]     hi;
    logic [COORD_W:0]          r;
    sh = SH_W'(a >>> (T_FRAC + 1));
    hi = sh[SH_W-1:COORD_W-1];
    if (hi == '0 || hi == '1) begin
      r = {1'b0, sh[COORD_W-1:0]};
    end else if (sh[SH_W-1]) begin
      r = {1'b1, C_MIN};
    end else begin
      r = {1'b1, C_MAX};
    end
    return r;
  endfunction

  assign status.count_zero = (count == '0);
  assign full = (count == CNT_W'(MAX_POINTS));

  assign t_clamp   = (item.param_t > T_ONE) ? T_ONE : item.param_t;
  assign u_full    = U_W'(t_clamp) * U_W'(count);
  assign sq_full   = (2*T_FRAC)'(lt) * (2*T_FRAC)'(lt);
  assign cube_full = (2*T_FRAC)'(t2) * (2*T_FRAC)'(lt);

  assign s2  = $signed(W_W'(t2));
  assign s3  = $signed(W_W'(t3));
  assign sl  = $signed(W_W'(lt));
  assign two = $signed(W_W'(2) << T_FRAC);

  // neighbor seg-1+k clamped to the stored range
  assign nb   = $signed(NI_W'(seg)) + $signed(NI_W'(cmd.mac_step[1:0])) - NI_W'(1);
  assign last = $signed(NI_W'(count)) - NI_W'(1);
  always_comb begin
    if (nb < 0) begin
      nb_addr = '0;
    end else if (nb > last) begin
      nb_addr = last[AW-1:0];
    end else begin
      nb_addr = nb[AW-1:0];
    end
  end

  assign issue = cmd.mac_run && (cmd.mac_step <= STEP_LAST_ISSUE);
  assign mult  = cmd.mac_run && (cmd.mac_step >= STEP_FIRST_MUL)
                 && (cmd.mac_step <= STEP_LAST_MUL);
  assign accum = cmd.mac_run && (cmd.mac_step >= STEP_FIRST_ACC);
  assign w_sel = wgt[2'(cmd.mac_step - STEP_FIRST_MUL)];

  assign pt[0] = $signed(ram_rdata[2*COORD_W +: COORD_W]);
  assign pt[1] = $signed(ram_rdata[COORD_W +: COORD_W]);
  assign pt[2] = $signed(ram_rdata[0 +: COORD_W]);

  assign ram_we    = cmd.commit && (item.action == ACT_APPEND) && !full;
  assign ram_re    = issue || cmd.read_point;
  assign ram_raddr = cmd.read_point ? item.point_index[AW-1:0] : nb_addr;

  crse_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({item.pos_x, item.pos_y, item.pos_z}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin[i] = finish(acc[i]);
    end
  end

  always_comb begin
    out_next             = '0;
    out_next.point_total = TOTAL_W'(count);
    out_next.status      = ST_OK;
    unique case (item.action)
      ACT_APPEND: begin
        if (full) begin
          out_next.status = ST_FULL;
        end else begin
          out_next.point_total = TOTAL_W'(count) + TOTAL_W'(1);
        end
      end
      ACT_CLEAR: out_next.point_total = '0;
      ACT_EVAL: begin
        if (count == '0) begin
          out_next.status = ST_EMPTY;
        end else begin
          out_next.out_x     = $signed(fin[0][COORD_W-1:0]);
          out_next.out_y     = $signed(fin[1][COORD_W-1:0]);
          out_next.out_z     = $signed(fin[2][COORD_W-1:0]);
          out_next.saturated = fin[0][COORD_W] | fin[1][COORD_W] | fin[2][COORD_W];
        end
      end
      ACT_READ: begin
        if (TOTAL_W'(item.point_index) >= TOTAL_W'(count)) begin
          out_next.status = ST_BAD_INDEX;
        end else begin
          out_next.out_x = pt[0];
          out_next.out_y = pt[1];
          out_next.out_z = pt[2];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      if (item.action == ACT_CLEAR) begin
        count <= '0;
      end else if (item.action == ACT_APPEND && !full) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.calc_u) begin
      seg <= u_full[T_FRAC +: CNT_W];
      lt  <= u_full[T_FRAC-1:0];
    end
    if (cmd.calc_sq) begin
      t2 <= sq_full[T_FRAC +: T_FRAC];
    end
    if (cmd.calc_cube) begin
      t3 <= cube_full[T_FRAC +: T_FRAC];
    end
    if (cmd.calc_wgt) begin
      wgt[0] <= (s2 <<< 1) - s3 - sl;
      wgt[1] <= (s3 <<< 1) + s3 - (s2 <<< 2) - s2 + two;
      wgt[2] <= (s2 <<< 2) - (s3 <<< 1) - s3 + sl;
      wgt[3] <= s3 - s2;
    end
    for (int i = 0; i < 3; i++) begin
      if (mult) begin
        prod[i] <= PROD_W'(pt[i]) * PROD_W'(w_sel);
      end
      if (cmd.calc_wgt) begin
        acc[i] <= '0;
      end else if (accum) begin
        acc[i] <= acc[i] + ACC_W'(prod[i]);
      end
    end
    if (cmd.commit) begin
      out_data <= out_next;
    end
  end

endmodule

// ----- rtl/catmull_rom_spline_eval_unit.sv -----
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval_unit
// Uniform Catmull-Rom spline over a table of up to MAX_POINTS 3D points.
// ----------------------------------------------------------------------------
// Usage: in_valid/in_ready carry one transaction per action (append point,
// clear table, evaluate at param_t, read point back); out_valid/out_ready
// return exactly one result per transaction, in order, with the point count
// and a status code. MAX_POINTS ranges from 2 to 64.
// An append or a clear (and an evaluate on an empty table) goes straight to
// the result stage, a read first fetches the point from memory, and an
// evaluation computes u, L^2 and L^3, then the weights, then runs six steps
// in which the single read port of the point memory fetches the four
// neighbors while three multiply-accumulate lanes blend them. The unit takes
// the next transaction once a result is loaded, and one transaction at a time.
// A result waits in the output register while the next transaction is
// accepted; a stalled receiver only holds the unit when a second result is
// ready to be loaded. Reset empties the table and drops any pending result;
// the point memory itself is not cleared.
// ----------------------------------------------------------------------------
module catmull_rom_spline_eval_unit import crse_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  crse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  crse_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("unit accepted a transaction while one was in flight");

  a_total_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.point_total <= TOTAL_W'(MAX_POINTS))
    else $error("point count exceeds table size");

  a_full_means_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FULL |-> out_data.point_total == TOTAL_W'(MAX_POINTS))
    else $error("table full reported below capacity");

  a_sat_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |-> out_data.status == ST_OK)
    else $error("saturation flagged on a failed transaction");
`endif

endmodule
